### hw/rtl/clipped_bitmap_blit_address_gen_macros.svh
// Assertion macros for the blit address generator.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef CLIPPED_BITMAP_BLIT_ADDRESS_GEN_MACROS_SVH
`define CLIPPED_BITMAP_BLIT_ADDRESS_GEN_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication
`define CBB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbb: same-cycle check failed");
// Next-cycle implication
`define CBB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbb: next-cycle check failed");
`else
`define CBB_ASSERT_IMP(label, ante, cons)
`define CBB_ASSERT_NXT(label, ante, cons)
`endif
`endif

### hw/rtl/cbb_pkg.sv
`default_nettype none
package cbb_pkg;

  // Geometry is worked in a signed word wide enough for sums of 16-bit fields
  localparam int GEO_W    = 20;
  localparam int IDX_W    = 15;
  localparam int STRIDE_W = 13;
  // Counter widths cover the largest panel supported (2048 x 2048)
  localparam int ROWS_W   = 11;
  localparam int COLS_W   = 8;
  // Queue between front and back
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = 2;

  typedef logic signed [GEO_W-1:0] geo_t;

  typedef enum logic [1:0] {
    KIND_WINDOW = 2'd0,
    KIND_INDEX  = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_IDLE   = 2'd3
  } kind_t;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_NEXT  = 1'b1
  } func_t;

  typedef struct packed {
    logic               func;
    logic signed [15:0] part_x;
    logic signed [15:0] part_y;
    logic signed [15:0] src_width;
    logic signed [15:0] src_height;
    logic signed [15:0] dst_x;
    logic signed [15:0] dst_y;
    logic signed [15:0] dst_width;
    logic signed [15:0] dst_height;
    logic               invert_req;
    logic               mirror_req;
    logic               plane_sel;
  } in_t;

  typedef struct packed {
    kind_t             kind;
    logic [4:0]        col_start;
    logic [4:0]        col_end;
    logic [7:0]        row_start;
    logic [7:0]        row_end;
    logic [IDX_W-1:0]  byte_index;
    logic              invert_out;
    logic              plane_out;
    logic              last;
  } out_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic                is_next;
    out_t                res;
    logic                active;
    logic [IDX_W-1:0]    col_base;
    logic [IDX_W-1:0]    row_base;
    logic [STRIDE_W-1:0] stride;
    logic [ROWS_W-1:0]   rows_last;
    logic [COLS_W-1:0]   cols_last;
    logic                invert;
    logic                mirror;
    logic                plane;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

### hw/rtl/cbb_front.sv
`default_nettype none
module cbb_front #(
  parameter int PANEL_WIDTH  = 200,
  parameter int PANEL_HEIGHT = 200
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire cbb_pkg::in_t    in_data,
  input  wire cbb_pkg::q_stat_t q_stat,
  output logic                 push,
  output cbb_pkg::job_t        push_data
);
  import cbb_pkg::*;

  typedef struct packed {
    logic func;
    logic inv;
    logic mir;
    logic pl;
  } flags_t;

  localparam geo_t PW_G = geo_t'(PANEL_WIDTH);
  localparam geo_t PH_G = geo_t'(PANEL_HEIGHT);

  logic fe_en;

  // ---------------- stage 1: range checks, part rounding, size limits
  geo_t xp, yp, wbm, hbm, x, y, w, h;
  geo_t xpr, wa, wmin, ha, hmin, xfl, xr, wsum;
  logic rej1;
  flags_t fl_in;

  always_comb begin
    xp   = geo_t'($signed(in_data.part_x));
    yp   = geo_t'($signed(in_data.part_y));
    wbm  = geo_t'($signed(in_data.src_width));
    hbm  = geo_t'($signed(in_data.src_height));
    x    = geo_t'($signed(in_data.dst_x));
    y    = geo_t'($signed(in_data.dst_y));
    w    = geo_t'($signed(in_data.dst_width));
    h    = geo_t'($signed(in_data.dst_height));
    rej1 = (wbm < 0) || (hbm < 0) || (w < 0) || (h < 0) ||
           (xp < 0) || (xp >= wbm) || (yp < 0) || (yp >= hbm);
    wsum = wbm + geo_t'(7);
    xpr  = geo_t'({xp[GEO_W-1:3], 3'b000});
    wa   = wbm - xpr;
    wmin = (wa < w) ? wa : w;
    ha   = hbm - yp;
    hmin = (ha < h) ? ha : h;
    // round toward zero to a byte boundary
    xfl  = geo_t'({x[GEO_W-1:3], 3'b000});
    xr   = ((x < 0) && (x[2:0] != 3'b000)) ? xfl + geo_t'(8) : xfl;
    fl_in = '{func: in_data.func, inv: in_data.invert_req,
              mir: in_data.mirror_req, pl: in_data.plane_sel};
  end

  logic                s1_valid_r;
  flags_t              s1_fl_r;
  logic                s1_rej_r;
  logic [STRIDE_W-1:0] s1_stride_r;
  logic [IDX_W-1:0]    s1_xpcol_r;
  geo_t                s1_yp_r, s1_hbm_r, s1_y_r, s1_xr_r, s1_wmin_r, s1_hmin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (fe_en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fe_en) begin
      s1_fl_r     <= fl_in;
      s1_rej_r    <= rej1;
      s1_stride_r <= wsum[STRIDE_W+2:3];
      s1_xpcol_r  <= xp[IDX_W+2:3];
      s1_yp_r     <= yp;
      s1_hbm_r    <= hbm;
      s1_y_r      <= y;
      s1_xr_r     <= xr;
      s1_wmin_r   <= wmin;
      s1_hmin_r   <= hmin;
    end
  end

  // ---------------- stage 2: width rounding, panel clip terms
  geo_t wr_sum, wr, x1, y1, dx, dy, pwmx, pwmx1, phmy, phmy1, srow0;

  always_comb begin
    wr_sum = s1_wmin_r + geo_t'(7);
    wr     = geo_t'({wr_sum[GEO_W-1:3], 3'b000});
    x1     = (s1_xr_r < 0) ? geo_t'(0) : s1_xr_r;
    dx     = (s1_xr_r < 0) ? geo_t'(0) - s1_xr_r : geo_t'(0);
    y1     = (s1_y_r < 0) ? geo_t'(0) : s1_y_r;
    dy     = (s1_y_r < 0) ? geo_t'(0) - s1_y_r : geo_t'(0);
    pwmx   = PW_G - s1_xr_r;
    pwmx1  = PW_G - x1;
    phmy   = PH_G - s1_y_r;
    phmy1  = PH_G - y1;
    srow0  = s1_yp_r + dy;
  end

  logic                s2_valid_r;
  flags_t              s2_fl_r;
  logic                s2_rej_r;
  logic [STRIDE_W-1:0] s2_stride_r;
  logic [IDX_W-1:0]    s2_xpcol_r;
  geo_t                s2_hbm_r, s2_hmin_r, s2_wr_r, s2_x1_r, s2_y1_r, s2_dx_r, s2_dy_r;
  geo_t                s2_pwmx_r, s2_pwmx1_r, s2_phmy_r, s2_phmy1_r, s2_srow0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (fe_en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fe_en) begin
      s2_fl_r     <= s1_fl_r;
      s2_rej_r    <= s1_rej_r;
      s2_stride_r <= s1_stride_r;
      s2_xpcol_r  <= s1_xpcol_r;
      s2_hbm_r    <= s1_hbm_r;
      s2_hmin_r   <= s1_hmin_r;
      s2_wr_r     <= wr;
      s2_x1_r     <= x1;
      s2_y1_r     <= y1;
      s2_dx_r     <= dx;
      s2_dy_r     <= dy;
      s2_pwmx_r   <= pwmx;
      s2_pwmx1_r  <= pwmx1;
      s2_phmy_r   <= phmy;
      s2_phmy1_r  <= phmy1;
      s2_srow0_r  <= srow0;
    end
  end

  // ---------------- stage 3: clipped size, first source row and column
  geo_t             w1, h1, srow_m;
  logic [IDX_W-1:0] srow, col_base;

  always_comb begin
    // right and bottom clip: keep the request when it ends inside the panel
    w1       = (s2_wr_r < s2_pwmx_r) ? s2_wr_r - s2_dx_r : s2_pwmx1_r;
    h1       = (s2_hmin_r < s2_phmy_r) ? s2_hmin_r - s2_dy_r : s2_phmy1_r;
    srow_m   = s2_hbm_r - geo_t'(1) - s2_srow0_r;
    srow     = s2_fl_r.mir ? srow_m[IDX_W-1:0] : s2_srow0_r[IDX_W-1:0];
    col_base = s2_xpcol_r + s2_dx_r[IDX_W+2:3];
  end

  logic                s3_valid_r;
  flags_t              s3_fl_r;
  logic                s3_rej_r;
  logic [STRIDE_W-1:0] s3_stride_r;
  logic [IDX_W-1:0]    s3_srow_r, s3_col_base_r;
  geo_t                s3_w1_r, s3_h1_r, s3_x1_r, s3_y1_r;

  // Hold the whole front while the last stage cannot hand off
  always_comb begin
    fe_en    = !(s3_valid_r && q_stat.full);
    in_stall = !fe_en;
    push     = s3_valid_r && fe_en;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (fe_en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fe_en) begin
      s3_fl_r       <= s2_fl_r;
      s3_rej_r      <= s2_rej_r;
      s3_stride_r   <= s2_stride_r;
      s3_srow_r     <= srow;
      s3_col_base_r <= col_base;
      s3_w1_r       <= w1;
      s3_h1_r       <= h1;
      s3_x1_r       <= x1_pass(s2_x1_r);
      s3_y1_r       <= s2_y1_r;
    end
  end

  function automatic geo_t x1_pass(geo_t v);
    return v;
  endfunction

  // ---------------- classify: window fields, reject, job counts
  geo_t               xend, yend, rows_m1;
  logic               rej;
  logic [COLS_W:0]    cols_tot, cols_m1;

  always_comb begin
    rej      = s3_rej_r || (s3_w1_r <= 0) || (s3_h1_r <= 0);
    xend     = s3_x1_r + s3_w1_r - geo_t'(1);
    yend     = s3_y1_r + s3_h1_r - geo_t'(1);
    rows_m1  = s3_h1_r - geo_t'(1);
    cols_tot = s3_w1_r[COLS_W+3:3];
    cols_m1  = cols_tot - 1'b1;

    push_data           = '0;
    push_data.is_next   = (s3_fl_r.func == FUNC_NEXT);
    push_data.col_base  = s3_col_base_r;
    push_data.row_base  = s3_srow_r;
    push_data.stride    = s3_stride_r;
    push_data.rows_last = rows_m1[ROWS_W-1:0];
    push_data.cols_last = cols_m1[COLS_W-1:0];
    push_data.invert    = s3_fl_r.inv;
    push_data.mirror    = s3_fl_r.mir;
    push_data.plane     = s3_fl_r.pl;
    if (rej) begin
      push_data.active   = 1'b0;
      push_data.res.kind = KIND_REJECT;
    end else begin
      // a window narrower than one byte starts no job
      push_data.active         = (cols_tot != '0);
      push_data.res.kind       = KIND_WINDOW;
      push_data.res.col_start  = s3_x1_r[7:3];
      push_data.res.col_end    = xend[7:3];
      push_data.res.row_start  = s3_y1_r[7:0];
      push_data.res.row_end    = yend[7:0];
      push_data.res.invert_out = s3_fl_r.inv;
      push_data.res.plane_out  = s3_fl_r.pl;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/cbb_queue.sv
`default_nettype none
module cbb_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire cbb_pkg::job_t    push_data,
  input  wire logic             pop,
  output cbb_pkg::job_t         pop_data,
  output cbb_pkg::q_stat_t      q_stat
);
  import cbb_pkg::*;

  job_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
    q_stat.full  = (count_r == (Q_AW+1)'(Q_DEPTH));
    q_stat.empty = (count_r == '0);
    pop_data     = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/cbb_back.sv
`default_nettype none
module cbb_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cbb_pkg::q_stat_t q_stat,
  output logic                  pop,
  input  wire cbb_pkg::job_t    pop_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output cbb_pkg::out_t         out_data
);
  import cbb_pkg::*;

  logic be_en;

  // Job state
  logic                job_active_r, job_active_nxt;
  logic [ROWS_W-1:0]   row_cnt_r, row_cnt_nxt;
  logic [COLS_W-1:0]   col_cnt_r, col_cnt_nxt;
  logic [ROWS_W-1:0]   rows_last_r, rows_last_nxt;
  logic [COLS_W-1:0]   cols_last_r, cols_last_nxt;
  logic [IDX_W-1:0]    col_base_r, col_base_nxt;
  logic [IDX_W-1:0]    row_cur_r, row_cur_nxt;
  logic [STRIDE_W-1:0] stride_r, stride_nxt;
  logic                inv_r, inv_nxt;
  logic                mir_r, mir_nxt;
  logic                pl_r, pl_nxt;

  logic                       row_hit, col_hit, fin;
  logic [IDX_W-1:0]           col_sum;
  logic [IDX_W+STRIDE_W-1:0]  prod_full;
  out_t                       res_a;

  // Stage A / output registers
  logic             a_valid_r;
  logic             a_idx_r;
  out_t             a_res_r;
  logic [IDX_W-1:0] a_prod_r, a_colsum_r;
  logic             a_last_r, a_inv_r, a_pl_r;
  logic             out_valid_r;
  out_t             out_data_r;
  out_t             out_b;

  always_comb begin
    be_en     = !(out_valid_r && out_stall);
    pop       = !q_stat.empty && be_en;
    out_valid = out_valid_r;
    out_data  = out_data_r;
  end

  // Step the byte walk; load a new job on a start entry
  always_comb begin
    row_hit   = (row_cnt_r == rows_last_r);
    col_hit   = (col_cnt_r == cols_last_r);
    fin       = row_hit && col_hit;
    col_sum   = col_base_r + IDX_W'(col_cnt_r);
    prod_full = row_cur_r * stride_r;

    job_active_nxt = job_active_r;
    row_cnt_nxt    = row_cnt_r;
    col_cnt_nxt    = col_cnt_r;
    rows_last_nxt  = rows_last_r;
    cols_last_nxt  = cols_last_r;
    col_base_nxt   = col_base_r;
    row_cur_nxt    = row_cur_r;
    stride_nxt     = stride_r;
    inv_nxt        = inv_r;
    mir_nxt        = mir_r;
    pl_nxt         = pl_r;
    res_a          = '0;

    if (pop) begin
      if (!pop_data.is_next) begin
        job_active_nxt = pop_data.active;
        row_cnt_nxt    = '0;
        col_cnt_nxt    = '0;
        rows_last_nxt  = pop_data.rows_last;
        cols_last_nxt  = pop_data.cols_last;
        col_base_nxt   = pop_data.col_base;
        row_cur_nxt    = pop_data.row_base;
        stride_nxt     = pop_data.stride;
        inv_nxt        = pop_data.invert;
        mir_nxt        = pop_data.mirror;
        pl_nxt         = pop_data.plane;
        res_a          = pop_data.res;
      end else if (job_active_r) begin
        if (fin) begin
          job_active_nxt = 1'b0;
        end else if (col_hit) begin
          col_cnt_nxt = '0;
          row_cnt_nxt = row_cnt_r + 1'b1;
          row_cur_nxt = mir_r ? row_cur_r - 1'b1 : row_cur_r + 1'b1;
        end else begin
          col_cnt_nxt = col_cnt_r + 1'b1;
        end
      end else begin
        res_a.kind = KIND_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_active_r <= 1'b0;
    end else begin
      job_active_r <= job_active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_cnt_r   <= row_cnt_nxt;
    col_cnt_r   <= col_cnt_nxt;
    rows_last_r <= rows_last_nxt;
    cols_last_r <= cols_last_nxt;
    col_base_r  <= col_base_nxt;
    row_cur_r   <= row_cur_nxt;
    stride_r    <= stride_nxt;
    inv_r       <= inv_nxt;
    mir_r       <= mir_nxt;
    pl_r        <= pl_nxt;
  end

  // Stage A: register row product and column sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (be_en) begin
      a_valid_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (be_en) begin
      a_idx_r    <= pop_data.is_next && job_active_r;
      a_res_r    <= res_a;
      a_prod_r   <= prod_full[IDX_W-1:0];
      a_colsum_r <= col_sum;
      a_last_r   <= fin;
      a_inv_r    <= inv_r;
      a_pl_r     <= pl_r;
    end
  end

  // Output stage: finish the index, hold while stalled
  always_comb begin
    out_b = a_res_r;
    if (a_idx_r) begin
      out_b            = '0;
      out_b.kind       = KIND_INDEX;
      out_b.byte_index = a_prod_r + a_colsum_r;
      out_b.invert_out = a_inv_r;
      out_b.plane_out  = a_pl_r;
      out_b.last       = a_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (be_en) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (be_en) begin
      out_data_r <= out_b;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/clipped_bitmap_blit_address_gen.sv
`default_nettype none
// Channel  | Handshake           | Payload
// ---------+---------------------+-------------------------------
// in       | in_valid, in_stall  | in_data  (start or next item)
// out      | out_valid, out_stall| out_data (window/index/reject/idle)
//
// One item per cycle while nothing stalls; after acceptance a result passes
// through three front stages, the queue and two back stages, in that order.
// The back walk issues one byte index per cycle unless stalled or starved, from
// incremental counters and one 15x13 multiply, registered before the final add.
// rst_n is synchronous; after reset no job is active and the queue is empty.
// out_stall holds the back stages; in_stall rises only when the four-entry
// queue is full and the front's last stage holds an item.
`include "clipped_bitmap_blit_address_gen_macros.svh"
module clipped_bitmap_blit_address_gen #(
  parameter int PANEL_WIDTH  = 200,
  parameter int PANEL_HEIGHT = 200
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire cbb_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output cbb_pkg::out_t      out_data
);
  import cbb_pkg::*;

  logic    push, pop;
  job_t    push_data, pop_data;
  q_stat_t q_stat;

  cbb_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  cbb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  cbb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop       (pop),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Queue never written when full
  `CBB_ASSERT_IMP(a_no_overflow, push, !q_stat.full)
  // Front stalls only for a full queue
  `CBB_ASSERT_IMP(a_front_free, !q_stat.full, !in_stall)
  // No entry leaves while a result waits on a stalled output
  `CBB_ASSERT_IMP(a_pop_held, out_valid && out_stall, !pop)
  // A lone write leaves the queue occupied
  `CBB_ASSERT_NXT(a_push_lands, push && !pop, !q_stat.empty)

endmodule
`default_nettype wire
